// ----- src/heightmap_triangle_interpolation_top_defines.svh -----
// Assertion macros shared by the heightmap query checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef HEIGHTMAP_TRIANGLE_INTERPOLATION_TOP_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_INTERPOLATION_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define HTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/hti_pkg.sv -----
// Shared constants for the heightmap triangle interpolation block.
// Used by the top level and its port checker; no dependencies.
`default_nettype none

package hti_pkg;

  localparam int HTI_MAX_SIDE = 128;

  localparam int COL_W  = 7;
  localparam int HGT_W  = 16;
  localparam int CRD_W  = 20;
  localparam int SIZE_W = 8;
  localparam int ISC_W  = 24;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 24;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_AW-1:0] CFG_GRID_WIDTH = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_GRID_DEPTH = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_INV_SCALE  = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [SIZE_W-1:0] GRID_RST = 8'd128;
  localparam logic [ISC_W-1:0]  ISC_RST  = 24'h010000;

endpackage

`default_nettype wire

// ----- src/heightmap_triangle_interpolation_top.sv -----
// Heightmap query: write beats load one entry, query beats return one planar height.
// Write beats are taken every cycle while no query is in flight. A query is scaled in x
// and z on the shared multiplier, range checked, and reads three corners on the single
// read port of the height store (off grid it skips the reads); the next beat is taken
// only after its result enters the output register. Synchronous active-low reset
// clears control and restores the grid registers; the store is kept.
`default_nettype none

module heightmap_triangle_interpolation_top #(
  parameter int MAX_SIDE = hti_pkg::HTI_MAX_SIDE
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // write_col[6:0], write_row[13:7], write_height[29:14], query_x[49:30], query_z[69:50]
  input  wire  [hti_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode[0]
  input  wire  [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // height[15:0]
  output logic [hti_pkg::OUT_DATA_W-1:0]   out_tdata,
  // in_range[0]
  output logic [0:0]                       out_tuser,
  input  wire                              cfg_we,
  input  wire  [hti_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire  [hti_pkg::CFG_DW-1:0]       cfg_wdata
);
  import hti_pkg::*;

  localparam int SW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int AW = 2 * SW;
  localparam int DEPTH = 1 << AW;
  localparam int CW = (SW > COL_W) ? SW : COL_W;
  localparam int PW = CRD_W + ISC_W + 1;

  localparam logic [1:0] CRN_A = 2'd0;
  localparam logic [1:0] CRN_T = 2'd1;
  localparam logic [1:0] CRN_B = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MX   = 8'b0000_0010,
    S_MZ   = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_WAIT = 8'b0010_0000,
    S_MUL  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] grid_width_r, grid_depth_r;
  logic [ISC_W-1:0]  inv_scale_r;

  logic [HGT_W-1:0]  mem [DEPTH];
  logic [HGT_W-1:0]  mem_q_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     wr_addr, rd_addr;

  logic signed [CRD_W-1:0] qx_r, qz_r;
  logic signed [PW-1:0]    prod_r;
  logic [SW-1:0]           cx_r, cz_r;
  logic [7:0]              fx_r;
  logic                    okx_r, ok_r, low_r;
  logic [8:0]              wt_r, wb_r;
  logic [1:0]              rd_cnt_r, rd_tag_r;
  logic                    rd_pend_r;
  logic signed [HGT_W-1:0] ca_r, ct_r, cb_r;
  logic signed [26:0]      pt_r, pb_r;

  logic                    out_valid_r, out_in_range_r;
  logic [HGT_W-1:0]        out_height_r;

  // input fields
  logic [COL_W-1:0]        f_col, f_row;
  logic [HGT_W-1:0]        f_hgt;
  logic [CW-1:0]           wcol_ext, wrow_ext;
  logic                    in_acc;

  assign f_col    = in_tdata[6:0];
  assign f_row    = in_tdata[13:7];
  assign f_hgt    = in_tdata[29:14];
  assign wcol_ext = CW'(f_col);
  assign wrow_ext = CW'(f_row);
  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  assign mem_we  = in_acc && (in_tuser[0] == OP_WRITE)
                   && ({1'b0, wcol_ext} < (CW+1)'(MAX_SIDE))
                   && ({1'b0, wrow_ext} < (CW+1)'(MAX_SIDE));
  assign wr_addr = {wrow_ext[SW-1:0], wcol_ext[SW-1:0]};

  // scaling multiplier, shared by x and z
  logic signed [CRD_W-1:0] crd_sel;
  logic signed [PW-1:0]    prod;
  assign crd_sel = (state_r == S_MX) ? qx_r : qz_r;
  assign prod    = PW'(crd_sel * $signed({1'b0, inv_scale_r}));

  // grid decode of the registered product
  logic [SIZE_W-1:0] size_sel;
  logic [20:0]       size_c, idx_p1;
  logic              dec_ok;
  logic [SW-1:0]     dec_cell;
  logic [7:0]        dec_frac;
  assign size_sel = (state_r == S_MZ) ? grid_width_r : grid_depth_r;
  assign size_c   = (21'(size_sel) > 21'(MAX_SIDE)) ? 21'(MAX_SIDE) : 21'(size_sel);
  assign idx_p1   = 21'(prod_r[PW-2:24]) + 21'd1;
  assign dec_ok   = !prod_r[PW-1] && (idx_p1 < size_c);
  assign dec_cell = prod_r[SW+23:24];
  assign dec_frac = prod_r[23:16];

  logic [8:0] fsum;
  logic       tri_low;
  assign fsum    = {1'b0, fx_r} + {1'b0, dec_frac};
  assign tri_low = !fsum[8];

  // corner addresses
  logic [SW-1:0] cx1, cz1;
  assign cx1 = cx_r + 1'b1;
  assign cz1 = cz_r + 1'b1;
  assign mem_re = (state_r == S_RD);

  always_comb begin
    case (rd_cnt_r)
      CRN_A:   rd_addr = low_r ? {cz_r, cx_r} : {cz1, cx1};
      CRN_T:   rd_addr = {cz_r, cx1};
      CRN_B:   rd_addr = {cz1, cx_r};
      default: rd_addr = {cz_r, cx_r};
    endcase
  end

  // interpolation sum, truncate toward zero, saturate
  logic signed [27:0] num, num_rnd;
  logic signed [19:0] q;
  logic [HGT_W-1:0]   q_sat;
  assign num     = $signed({{4{ca_r[HGT_W-1]}}, ca_r, 8'b0}) + 28'(pt_r) + 28'(pb_r);
  assign num_rnd = num[27] ? (num + 28'sd255) : num;
  assign q       = num_rnd[27:8];
  always_comb begin
    if (q > 20'sd32767) begin
      q_sat = 16'h7fff;
    end else if (q < -20'sd32768) begin
      q_sat = 16'h8000;
    end else begin
      q_sat = q[HGT_W-1:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser[0] == OP_QUERY)) begin
          state_nxt = S_MX;
        end
      end
      S_MX:   state_nxt = S_MZ;
      S_MZ:   state_nxt = S_CHK;
      S_CHK:  state_nxt = (okx_r && dec_ok) ? S_RD : S_OUT;
      S_RD: begin
        if (rd_cnt_r == CRN_B) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      rd_cnt_r     <= CRN_A;
      grid_width_r <= GRID_RST;
      grid_depth_r <= GRID_RST;
      inv_scale_r  <= ISC_RST;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= mem_re;
      if (state_r == S_CHK) begin
        rd_cnt_r <= CRN_A;
      end else if (mem_re) begin
        rd_cnt_r <= rd_cnt_r + 2'd1;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_GRID_WIDTH: grid_width_r <= cfg_wdata[SIZE_W-1:0];
          CFG_GRID_DEPTH: grid_depth_r <= cfg_wdata[SIZE_W-1:0];
          CFG_INV_SCALE:  inv_scale_r  <= cfg_wdata[ISC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= f_hgt;
    end
    if (mem_re) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      qx_r <= in_tdata[49:30];
      qz_r <= in_tdata[69:50];
    end
    if (state_r == S_MX || state_r == S_MZ) begin
      prod_r <= prod;
    end
    if (state_r == S_MZ) begin
      okx_r <= dec_ok;
      cx_r  <= dec_cell;
      fx_r  <= dec_frac;
    end
    if (state_r == S_CHK) begin
      ok_r  <= okx_r && dec_ok;
      cz_r  <= dec_cell;
      low_r <= tri_low;
      wt_r  <= tri_low ? {1'b0, fx_r} : (9'd256 - {1'b0, dec_frac});
      wb_r  <= tri_low ? {1'b0, dec_frac} : (9'd256 - {1'b0, fx_r});
    end
    if (mem_re) begin
      rd_tag_r <= rd_cnt_r;
    end
    if (rd_pend_r) begin
      case (rd_tag_r)
        CRN_A:   ca_r <= mem_q_r;
        CRN_T:   ct_r <= mem_q_r;
        default: cb_r <= mem_q_r;
      endcase
    end
    if (state_r == S_MUL) begin
      pt_r <= 27'((17'(ct_r) - 17'(ca_r)) * $signed({1'b0, wt_r}));
      pb_r <= 27'((17'(cb_r) - 17'(ca_r)) * $signed({1'b0, wb_r}));
    end
    if (state_r == S_OUT && out_free) begin
      out_height_r   <= ok_r ? q_sat : '0;
      out_in_range_r <= ok_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_height_r;
  assign out_tuser[0] = out_in_range_r;

endmodule

`default_nettype wire

// ----- src/hti_checker.sv -----
// Port-level checks for the heightmap query block, bound to the top level.
// Depends on hti_pkg and the assertion macro header.
`default_nettype none
`include "heightmap_triangle_interpolation_top_defines.svh"

module hti_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire [0:0]                       in_tuser,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [hti_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire [0:0]                       out_tuser
);
  import hti_pkg::*;

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  `HTI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result beat changed")
  `HTI_ASSERT_NOW(a_off_grid_zero, out_tvalid && !out_tuser[0], out_tdata == '0, "off-grid result with non-zero height")
  `HTI_ASSERT_NEXT(a_query_busy, in_beat && (in_tuser[0] == OP_QUERY), !in_tready, "query beat did not block the input")
  `HTI_ASSERT_NEXT(a_write_ready, in_beat && (in_tuser[0] == OP_WRITE), in_tready, "write beat stalled the input")

endmodule

bind heightmap_triangle_interpolation_top hti_checker u_hti_checker (.*);

`default_nettype wire

// ----- test/tb_heightmap_triangle_interpolation_top.sv -----
// Self-checking bench for heightmap_triangle_interpolation_top: loads heights over the
// input stream, queries planar heights, checks results against a local predictor or a
// known value. Uses hti_pkg and the top level only; random idling on both stream sides.
`timescale 1ns / 1ps

module tb_heightmap_triangle_interpolation_top;
  import hti_pkg::*;

  typedef struct packed {
    logic [HGT_W-1:0] hgt;
    logic             in_range;
  } height_result_t;

  typedef struct {
    logic             op;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
    logic [HGT_W-1:0] hgt;
    logic [CRD_W-1:0] qx;
    logic [CRD_W-1:0] qz;
    bit               known;
    height_result_t   want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_we;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [CFG_DW-1:0]     cfg_wdata;

  // predictor state
  logic signed [HGT_W-1:0] height_mem [HTI_MAX_SIDE*HTI_MAX_SIDE];
  bit                      entry_written [HTI_MAX_SIDE*HTI_MAX_SIDE];
  logic [SIZE_W-1:0]       grid_width_q;
  logic [SIZE_W-1:0]       grid_depth_q;
  logic [ISC_W-1:0]        inv_scale_q;
  height_result_t          heights_due[$];

  int  errors;
  int  n_writes;
  int  n_queries;
  int  n_results;
  int  n_hits;
  int  n_settings;
  bit  burst_phase;

  heightmap_triangle_interpolation_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("** heightmap_triangle_interpolation_top: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 50) begin
      $display("%0t: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic longint active_span(input logic [SIZE_W-1:0] size_reg);
    return (size_reg > HTI_MAX_SIDE) ? HTI_MAX_SIDE : longint'(size_reg);
  endfunction

  function automatic bit scale_to_cell(input logic signed [CRD_W-1:0] crd,
                                       input logic [SIZE_W-1:0] size_reg,
                                       output int cell_idx, output int frac);
    longint prod;
    longint g;
    longint idx;
    prod = longint'(crd) * longint'(inv_scale_q);
    cell_idx = 0;
    frac = 0;
    if (prod < 0) return 1'b0;
    g   = prod >>> 16;
    idx = g >>> 8;
    if (idx >= active_span(size_reg) - 1) return 1'b0;
    cell_idx = int'(idx);
    frac = int'(g & 255);
    return 1'b1;
  endfunction

  function automatic height_result_t interpolate_height(input logic [CRD_W-1:0] qx,
                                                        input logic [CRD_W-1:0] qz);
    int             cx, cz, fx, fz;
    longint         tl, tr, bl, br, num, q;
    height_result_t res;
    res = '0;
    if (!scale_to_cell(qx, grid_width_q, cx, fx) || !scale_to_cell(qz, grid_depth_q, cz, fz))
      return res;
    tl = longint'(height_mem[cz * HTI_MAX_SIDE + cx]);
    tr = longint'(height_mem[cz * HTI_MAX_SIDE + cx + 1]);
    bl = longint'(height_mem[(cz + 1) * HTI_MAX_SIDE + cx]);
    br = longint'(height_mem[(cz + 1) * HTI_MAX_SIDE + cx + 1]);
    if (fx + fz < 256)
      num = tl * 256 + (tr - tl) * fx + (bl - tl) * fz;
    else
      num = br * 256 + (bl - br) * (256 - fx) + (tr - br) * (256 - fz);
    q = num / 256;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    res.hgt      = q[HGT_W-1:0];
    res.in_range = 1'b1;
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_phase) return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CRD_W-1:0] coord_for_grid(input longint g);
    longint x;
    if (inv_scale_q == '0) return CRD_W'($urandom);
    x = ((g << 16) + longint'(inv_scale_q) - 1) / longint'(inv_scale_q);
    if (x > 524287) x = 524287;
    return x[CRD_W-1:0];
  endfunction

  function automatic logic [CRD_W-1:0] aim_coord(input logic [SIZE_W-1:0] size_reg);
    longint span;
    int     roll;
    span = active_span(size_reg);
    if (span < 2) span = 2;
    roll = $urandom_range(0, 99);
    if (roll < 8) return CRD_W'(-longint'($urandom_range(1, 524288)));
    if (roll < 14) return CRD_W'($urandom);
    return coord_for_grid($urandom_range(0, span * 256 + 127));
  endfunction

  task automatic send_beat(input logic op, input logic [COL_W-1:0] col,
                           input logic [COL_W-1:0] row, input logic [HGT_W-1:0] hgt,
                           input logic [CRD_W-1:0] qx, input logic [CRD_W-1:0] qz,
                           input bit known, input height_result_t want);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {2'b00, qz, qx, hgt, row, col};
    do @(posedge clk); while (!in_tready);
    if (op == OP_WRITE) begin
      height_mem[{row, col}]    = hgt;
      entry_written[{row, col}] = 1'b1;
      n_writes++;
    end else begin
      heights_due.insert(heights_due.size(), known ? want : interpolate_height(qx, qz));
      n_queries++;
    end
    @(negedge clk);
  endtask

  // load any corner of the target cell that holds no height yet
  task automatic prime_corners(input logic [CRD_W-1:0] qx, input logic [CRD_W-1:0] qz,
                               inout int issued);
    int cx, cz, fx, fz;
    if (scale_to_cell(qx, grid_width_q, cx, fx) && scale_to_cell(qz, grid_depth_q, cz, fz)) begin
      for (int dz = 0; dz < 2; dz++) begin
        for (int dx = 0; dx < 2; dx++) begin
          if (!entry_written[(cz + dz) * HTI_MAX_SIDE + cx + dx]) begin
            send_beat(OP_WRITE, COL_W'(cx + dx), COL_W'(cz + dz), HGT_W'($urandom),
                      CRD_W'($urandom), CRD_W'($urandom), 1'b0, '0);
            issued++;
          end
        end
      end
    end
  endtask

  task automatic settle_pipeline();
    in_tvalid = 1'b0;
    while (heights_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (addr)
      CFG_GRID_WIDTH: grid_width_q = value[SIZE_W-1:0];
      CFG_GRID_DEPTH: grid_depth_q = value[SIZE_W-1:0];
      CFG_INV_SCALE:  inv_scale_q  = value[ISC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_random(input int budget);
    int               issued;
    int               fxx;
    longint           gx, gz;
    logic [CRD_W-1:0] qx, qz;
    bit               drained;
    issued  = 0;
    drained = 1'b0;
    burst_phase = ($urandom_range(0, 3) == 0);
    while (issued < budget) begin
      if (!drained && issued >= budget / 2) begin
        settle_pipeline();
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 30) begin
        send_beat(OP_WRITE, COL_W'($urandom), COL_W'($urandom), HGT_W'($urandom),
                  CRD_W'($urandom), CRD_W'($urandom), 1'b0, '0);
        issued++;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          // land on the diagonal between the two triangles
          fxx = $urandom_range(1, 255);
          gx  = $urandom_range(0, 126) * 256 + fxx;
          gz  = $urandom_range(0, 126) * 256 + (256 - fxx);
          if (active_span(grid_width_q) >= 2)
            gx = (gx >> 8) % (active_span(grid_width_q) - 1) * 256 + fxx;
          if (active_span(grid_depth_q) >= 2)
            gz = (gz >> 8) % (active_span(grid_depth_q) - 1) * 256 + (256 - fxx);
          qx = coord_for_grid(gx);
          qz = coord_for_grid(gz);
        end else begin
          qx = aim_coord(grid_width_q);
          qz = aim_coord(grid_depth_q);
        end
        prime_corners(qx, qz, issued);
        send_beat(OP_QUERY, COL_W'($urandom), COL_W'($urandom), HGT_W'($urandom), qx, qz,
                  1'b0, '0);
        issued++;
      end
    end
    burst_phase = 1'b0;
  endtask

  function automatic stim_row_t write_row(input logic [COL_W-1:0] col,
                                          input logic [COL_W-1:0] row,
                                          input logic [HGT_W-1:0] hgt);
    stim_row_t r;
    r = '{OP_WRITE, col, row, hgt, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t query_row(input logic [CRD_W-1:0] qx,
                                          input logic [CRD_W-1:0] qz, input bit known,
                                          input logic [HGT_W-1:0] hgt, input logic in_range);
    stim_row_t r;
    r = '{OP_QUERY, '0, '0, '0, qx, qz, known, '{hgt, in_range}};
    return r;
  endfunction

  // stall the result side in short and long stretches
  initial begin
    int roll;
    out_tready = 1'b0;
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else if (roll < 65) begin
        out_tready = 1'b1;
        repeat ($urandom_range(40, 120)) @(negedge clk);
      end else if (roll < 95) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_tready = 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    height_result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (heights_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: height %0d in_range %0d",
                                  $signed(out_tdata), out_tuser[0]));
      end else begin
        due = heights_due.pop_front();
        if (out_tdata !== due.hgt)
          report_mismatch($sformatf("height: got %0d want %0d", $signed(out_tdata),
                                    $signed(due.hgt)));
        if (out_tuser[0] !== due.in_range)
          report_mismatch($sformatf("in_range: got %0b want %0b", out_tuser[0],
                                    due.in_range));
        n_results++;
        if (due.in_range) n_hits++;
      end
    end
  end

  initial begin
    stim_row_t   directed_rows[21];
    int unsigned phase_w[9];
    int unsigned phase_d[9];
    int unsigned phase_s[9];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    errors = 0; n_writes = 0; n_queries = 0; n_results = 0; n_hits = 0; n_settings = 1;
    burst_phase  = 1'b0;
    grid_width_q = GRID_RST;
    grid_depth_q = GRID_RST;
    inv_scale_q  = ISC_RST;
    foreach (entry_written[i]) entry_written[i] = 1'b0;
    foreach (height_mem[i]) height_mem[i] = '0;

    directed_rows = '{
      write_row(0, 0, 16'h7FFF), write_row(1, 0, 16'h7FFF),
      write_row(0, 1, 16'h7FFF), write_row(1, 1, 16'h7FFF),
      query_row(0, 0, 1'b1, 16'h7FFF, 1'b1),
      query_row(128, 128, 1'b1, 16'h7FFF, 1'b1),
      query_row(-1, 0, 1'b1, 16'h0000, 1'b0),
      query_row(524287, 0, 1'b1, 16'h0000, 1'b0),
      query_row(0, -524288, 1'b1, 16'h0000, 1'b0),
      write_row(126, 0, 16'h8000), write_row(127, 0, 16'h8000),
      write_row(126, 1, 16'h8000), write_row(127, 1, 16'h8000),
      query_row(126 * 256 + 255, 255, 1'b1, 16'h8000, 1'b1),
      query_row(127 * 256, 0, 1'b1, 16'h0000, 1'b0),
      query_row(0, 127 * 256, 1'b1, 16'h0000, 1'b0),
      write_row(2, 0, 16'hFFFF), write_row(2, 1, 16'h0000),
      query_row(356, 156, 1'b0, '0, 1'b0),
      query_row(356, 155, 1'b0, '0, 1'b0),
      query_row(511, 0, 1'b0, '0, 1'b0)
    };
    phase_w = '{2, 255, 0, 1, 17, 128, 64, 100, 128};
    phase_d = '{2, 200, 128, 1, 93, 2, 64, 37, 128};
    phase_s = '{65536, 24'hFFFFFF, 65536, 300000, 1, 0, 32768, 0, 200000};
    phase_s[7] = $urandom_range(1, 24'hFFFFFF);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].col, directed_rows[i].row,
                directed_rows[i].hgt, directed_rows[i].qx, directed_rows[i].qz,
                directed_rows[i].known, directed_rows[i].want);
    settle_pipeline();
    run_random(163);

    foreach (phase_w[p]) begin
      settle_pipeline();
      write_register(CFG_GRID_WIDTH, {16'($urandom_range(0, 65535)), phase_w[p][SIZE_W-1:0]});
      write_register(CFG_GRID_DEPTH, {16'($urandom_range(0, 65535)), phase_d[p][SIZE_W-1:0]});
      write_register(CFG_INV_SCALE, phase_s[p][ISC_W-1:0]);
      n_settings++;
      run_random(163);
    end
    settle_pipeline();

    $display("Run covered %0d height writes and %0d queries over %0d register settings;",
             n_writes, n_queries, n_settings);
    $display("%0d results checked, %0d of them inside the grid.", n_results, n_hits);
    if (errors == 0) begin
      $display("** heightmap_triangle_interpolation_top: PASSED **");
    end else begin
      $display("** heightmap_triangle_interpolation_top: FAILED **");
    end
    $finish;
  end

endmodule
